// ===== sv/rlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reply line checker package
// Shared types, codes and character constants of the reply line checker.
// ----------------------------------------------------------------------------
package rlc_pkg;

    // Size of the controller's line buffer in bytes.
    localparam int BUF_BYTES = 256;
    localparam int PEND_W    = $clog2(BUF_BYTES);

    // Width of the timeout register.
    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Operation codes of an input item.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_ERROR    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Classes of a closed line.
    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_OK    = 3'd1;
    localparam logic [2:0] CLS_EMPTY = 3'd2;
    localparam logic [2:0] CLS_ERROR = 3'd3;
    localparam logic [2:0] CLS_WARN  = 3'd4;
    localparam logic [2:0] CLS_INFO  = 3'd5;
    localparam logic [2:0] CLS_UNEXP = 3'd6;

    // Characters that the parser looks for.
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Line length saturation point.
    localparam logic [2:0] LEN_SAT = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       done_res;
        logic       success;
        logic [2:0] status;
        logic [2:0] line_class;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/reply_line_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reply line checker
// Parses the reply byte stream of a serial display controller into lines
// and decides how the wait for a command reply ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one item
//   per handshake: start a new wait, a received byte, or an idle tick.
//   Output channel (o_out_valid / i_out_ready / o_out_item) returns exactly
//   one result item for every input item, in order.
//   The result of an item accepted at one edge is valid after that edge.
//   Throughput is one item per cycle while the receiver takes results; the
//   single result register is the only stage, and a new item is accepted
//   in the same cycle that the waiting result is taken. When the receiver
//   stalls, the result register holds its item and the input stops
//   accepting until the result is taken. Write the timeout register via
//   i_cfg_wr_en / i_cfg_wr_data only while the block is idle; the block
//   does not enforce it. Synchronous reset clears all parsing state,
//   empties the result register and loads the timeout register with 1000.
// ----------------------------------------------------------------------------
module reply_line_checker
    import rlc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [TICK_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire t_in_item          i_in_item,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      t_out_item         o_out_item
);

    // State registers.
    logic [TICK_W-1:0] r_timeout, n_timeout;
    logic              r_waiting, n_waiting;
    logic              r_ok_seen, n_ok_seen;
    logic              r_err_seen, n_err_seen;
    logic              r_stopped, n_stopped;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [2:0]        r_len, n_len;
    logic [7:0]        r_ch0, n_ch0;
    logic [7:0]        r_ch1, n_ch1;
    logic              r_cr, n_cr;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              in_fire;
    logic [2:0]        eff_len;
    logic [2:0]        close_cls;
    logic              close_ok;
    logic              close_err;
    logic              close_stop;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Classification of the open line as if a newline arrived now.
    always_comb begin
        eff_len    = r_len;
        close_ok   = 1'b0;
        close_err  = 1'b0;
        close_stop = 1'b0;
        if (r_cr && (r_len != 3'd0) && (r_len < LEN_SAT)) begin
            eff_len = r_len - 3'd1;
        end
        if ((eff_len == 3'd2) && (r_ch0 == CH_O) && (r_ch1 == CH_K)) begin
            close_cls = CLS_OK;
            close_ok  = 1'b1;
        end else if (eff_len == 3'd0) begin
            close_cls = CLS_EMPTY;
        end else if ((eff_len >= 3'd2) && (r_ch1 == CH_COLON)) begin
            if (r_ch0 == CH_E) begin
                close_cls = CLS_ERROR;
                close_err = 1'b1;
            end else if (r_ch0 == CH_W) begin
                close_cls = CLS_WARN;
            end else if (r_ch0 == CH_I) begin
                close_cls = CLS_INFO;
            end else begin
                close_cls = CLS_UNEXP;
                close_err = 1'b1;
            end
        end else begin
            close_cls  = CLS_UNEXP;
            close_err  = 1'b1;
            close_stop = 1'b1;
        end
    end

    // Next state and result of the accepted item.
    always_comb begin
        n_timeout   = r_timeout;
        n_waiting   = r_waiting;
        n_ok_seen   = r_ok_seen;
        n_err_seen  = r_err_seen;
        n_stopped   = r_stopped;
        n_ticks     = r_ticks;
        n_len       = r_len;
        n_ch0       = r_ch0;
        n_ch1       = r_ch1;
        n_cr        = r_cr;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cfg_wr_en) begin
            n_timeout = i_cfg_wr_data;
        end

        if (in_fire) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            case (i_in_item.op)
                OP_START: begin
                    n_waiting  = 1'b1;
                    n_ok_seen  = 1'b0;
                    n_err_seen = 1'b0;
                    n_stopped  = 1'b0;
                    n_ticks    = r_timeout;
                    n_len      = '0;
                    n_ch0      = '0;
                    n_ch1      = '0;
                    n_cr       = 1'b0;
                    n_pend     = '0;
                end
                OP_BYTE: begin
                    if (r_waiting) begin
                        if (r_pend >= PEND_W'(BUF_BYTES - 1)) begin
                            n_waiting      = 1'b0;
                            n_out.done_res = 1'b1;
                            n_out.status   = ST_OVERFLOW;
                        end else begin
                            n_pend = r_pend + PEND_W'(1);
                            if (!r_stopped) begin
                                if (i_in_item.rx_byte == CH_LF) begin
                                    // Newline closes the open line.
                                    n_out.line_class = close_cls;
                                    n_ok_seen  = r_ok_seen || close_ok;
                                    n_err_seen = r_err_seen || close_err;
                                    n_stopped  = close_stop;
                                    if (!close_stop) begin
                                        n_pend = '0;
                                    end
                                    n_len = '0;
                                    n_ch0 = '0;
                                    n_ch1 = '0;
                                    n_cr  = 1'b0;
                                end else begin
                                    // Keep the first two bytes of the line.
                                    if (r_len == 3'd0) begin
                                        n_ch0 = i_in_item.rx_byte;
                                    end else if (r_len == 3'd1) begin
                                        n_ch1 = i_in_item.rx_byte;
                                    end
                                    if (r_len < LEN_SAT) begin
                                        n_len = r_len + 3'd1;
                                    end
                                    n_cr = (i_in_item.rx_byte == CH_CR);
                                end
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (r_waiting) begin
                        if (r_ok_seen) begin
                            n_waiting      = 1'b0;
                            n_out.done_res = 1'b1;
                            n_out.success  = 1'b1;
                            n_out.status   = ST_OK;
                        end else if (r_err_seen) begin
                            n_waiting      = 1'b0;
                            n_out.done_res = 1'b1;
                            n_out.status   = ST_ERROR;
                        end else if (r_ticks <= TICK_W'(1)) begin
                            n_ticks        = '0;
                            n_waiting      = 1'b0;
                            n_out.done_res = 1'b1;
                            n_out.status   = ST_TIMEOUT;
                        end else begin
                            n_ticks = r_ticks - TICK_W'(1);
                        end
                    end
                end
                default: begin
                    // Unused operation code: the result stays all zeros.
                end
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_waiting   <= 1'b0;
            r_ok_seen   <= 1'b0;
            r_err_seen  <= 1'b0;
            r_stopped   <= 1'b0;
            r_ticks     <= '0;
            r_len       <= '0;
            r_ch0       <= '0;
            r_ch1       <= '0;
            r_cr        <= 1'b0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_timeout   <= n_timeout;
            r_waiting   <= n_waiting;
            r_ok_seen   <= n_ok_seen;
            r_err_seen  <= n_err_seen;
            r_stopped   <= n_stopped;
            r_ticks     <= n_ticks;
            r_len       <= n_len;
            r_ch0       <= n_ch0;
            r_ch1       <= n_ch1;
            r_cr        <= n_cr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef NO_ASSERTIONS
    // A result that does not end the wait reports neither success nor status.
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (!r_out.success && r_out.status == ST_BUSY))
        else $error("result without done carries success or status");

    // Success is reported only together with the ok status.
    a_success_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.success) |-> (r_out.done_res && r_out.status == ST_OK))
        else $error("success without ok status");

    // A start item always opens a wait with an empty buffer.
    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.op == OP_START) |=> (r_waiting && r_pend == '0))
        else $error("start item did not open a wait");

    // The line length never passes its saturation point.
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_SAT)
        else $error("line length beyond saturation");

    // A wait that ended produces a done result in the next cycle.
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_waiting && !n_waiting) |=> (r_out_valid && r_out.done_res))
        else $error("wait ended without a done result");
`endif

endmodule

`default_nettype wire
